/* src/swdh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdh_pkg
// Types and codes shared by the SWD host line engine.
// ----------------------------------------------------------------------------
`default_nettype none

package swdh_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int SEQ_IN_BITS = 64;

    localparam logic [1:0] FUNC_XFER = 2'd0;
    localparam logic [1:0] FUNC_SEQ  = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [2:0] ACK_OK    = 3'b001;
    localparam logic [2:0] ACK_WAIT  = 3'b010;
    localparam logic [2:0] ACK_FAULT = 3'b100;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_WAIT   = 3'd1;
    localparam logic [2:0] ST_FAULT  = 3'd2;
    localparam logic [2:0] ST_BADACK = 3'd3;
    localparam logic [2:0] ST_PARITY = 3'd4;

    localparam int REQ_BITS = 8;
    localparam int ACK_BITS = 3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_REQ,
        PH_TURN1,
        PH_ACK,
        PH_DATA,
        PH_TURN2,
        PH_SEQ
    } t_phase;

    typedef struct packed {
        logic [1:0]             func;
        logic [3:0]             request;
        logic [SEQ_IN_BITS-1:0] seq_bits;
        logic [6:0]             seq_length;
        logic                   swdio_in;
    } t_in;

    typedef struct packed {
        logic                  swclk;
        logic                  swdio_out;
        logic                  swdio_oe;
        logic                  busy_res;
        logic                  done_res;
        logic [2:0]            status;
        logic [2:0]            raw_ack;
        logic [DATA_WIDTH-1:0] read_data;
    } t_out;

endpackage

`default_nettype wire

/* src/swdh_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdh_core
// Line state and per-word step logic: one result word per accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module swdh_core #(
    parameter int SEQ_MAX_BITS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire swdh_pkg::t_in i_item,
    output swdh_pkg::t_out     o_res
);
    import swdh_pkg::*;

    localparam int SEQ_CW = $clog2(SEQ_MAX_BITS + 1);
    localparam int DAT_CW = $clog2(DATA_WIDTH + 2);
    localparam int CW     = (SEQ_CW > DAT_CW) ? SEQ_CW : DAT_CW;

    t_phase                  r_phase, n_phase;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_clk, n_clk;
    logic [SEQ_MAX_BITS-1:0] r_shift, n_shift;
    logic [2:0]              r_ack, n_ack;
    logic [DATA_WIDTH-1:0]   r_data, n_data;
    logic                    r_par, n_par;

    logic                    req_par;
    logic                    sdi;
    logic                    line_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_clk   <= 1'b1;
            r_shift <= '0;
            r_ack   <= '0;
            r_data  <= '0;
            r_par   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_clk   <= n_clk;
            r_shift <= n_shift;
            r_ack   <= n_ack;
            r_data  <= n_data;
            r_par   <= n_par;
        end
    end

    always_comb begin
        req_par = ^i_item.request;
        sdi     = i_item.swdio_in;
        line_in = (r_phase == PH_TURN1) || (r_phase == PH_ACK) ||
                  (r_phase == PH_DATA) || (r_phase == PH_TURN2);

        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_clk   = r_clk;
        n_shift = r_shift;
        n_ack   = r_ack;
        n_data  = r_data;
        n_par   = r_par;

        o_res           = '0;
        o_res.swclk     = 1'b1;
        o_res.swdio_out = 1'b1;
        o_res.swdio_oe  = 1'b1;

        if (i_item.func == FUNC_XFER || i_item.func == FUNC_SEQ) begin
            n_clk          = 1'b1;
            n_ack          = '0;
            n_data         = '0;
            n_par          = 1'b0;
            o_res.busy_res = 1'b1;
            if (i_item.func == FUNC_XFER) begin
                // start, request, parity, stop 0, park 1
                n_shift = SEQ_MAX_BITS'({1'b1, 1'b0, req_par, i_item.request, 1'b1});
                n_cnt   = '0;
                n_phase = PH_REQ;
            end else begin
                n_shift = i_item.seq_bits[SEQ_MAX_BITS-1:0];
                n_cnt   = (i_item.seq_length > 7'(SEQ_MAX_BITS)) ?
                          CW'(SEQ_MAX_BITS) : CW'(i_item.seq_length);
                n_phase = PH_SEQ;
            end
        end else if (i_item.func != FUNC_TICK || r_phase == PH_IDLE) begin
            o_res.swclk     = r_clk;
            o_res.swdio_oe  = !line_in;
            o_res.busy_res  = (r_phase != PH_IDLE);
            o_res.swdio_out = ((r_phase == PH_REQ || r_phase == PH_SEQ) && !r_clk) ?
                              r_shift[0] : 1'b1;
        end else if (r_phase == PH_SEQ && r_cnt == '0) begin
            n_phase        = PH_IDLE;
            n_clk          = 1'b1;
            o_res.done_res = 1'b1;
        end else if (r_clk) begin
            // low half: drive or sample
            n_clk          = 1'b0;
            o_res.swclk    = 1'b0;
            o_res.busy_res = 1'b1;
            o_res.swdio_oe = !line_in;
            case (r_phase)
                PH_REQ, PH_SEQ: begin
                    o_res.swdio_out = r_shift[0];
                end
                PH_ACK: begin
                    case (r_cnt[1:0])
                        2'd0:    n_ack[0] = r_ack[0] | sdi;
                        2'd1:    n_ack[1] = r_ack[1] | sdi;
                        2'd2:    n_ack[2] = r_ack[2] | sdi;
                        default: n_ack    = r_ack;
                    endcase
                end
                PH_DATA: begin
                    if (r_cnt < CW'(DATA_WIDTH)) begin
                        n_data = {sdi, r_data[DATA_WIDTH-1:1]};
                    end
                    n_par = r_par ^ sdi;
                end
                default: begin
                end
            endcase
        end else begin
            // high half: advance the bit
            n_clk          = 1'b1;
            o_res.busy_res = 1'b1;
            o_res.swdio_oe = !line_in;
            case (r_phase)
                PH_REQ: begin
                    o_res.swdio_out = r_shift[0];
                    n_shift = r_shift >> 1;
                    n_cnt   = r_cnt + CW'(1);
                    if (n_cnt >= CW'(REQ_BITS)) begin
                        n_cnt   = '0;
                        n_phase = PH_TURN1;
                    end
                end
                PH_SEQ: begin
                    o_res.swdio_out = r_shift[0];
                    n_shift = r_shift >> 1;
                    n_cnt   = r_cnt - CW'(1);
                    if (n_cnt == '0) begin
                        o_res.busy_res = 1'b0;
                        o_res.done_res = 1'b1;
                        n_phase        = PH_IDLE;
                    end
                end
                PH_TURN1: begin
                    n_cnt   = '0;
                    n_phase = PH_ACK;
                end
                PH_ACK: begin
                    n_cnt = r_cnt + CW'(1);
                    if (n_cnt >= CW'(ACK_BITS)) begin
                        n_cnt   = '0;
                        n_phase = (r_ack == ACK_OK) ? PH_DATA : PH_TURN2;
                    end
                end
                PH_DATA: begin
                    n_cnt = r_cnt + CW'(1);
                    if (n_cnt >= CW'(DATA_WIDTH + 1)) begin
                        n_cnt   = '0;
                        n_phase = PH_TURN2;
                    end
                end
                default: begin
                    o_res.busy_res = 1'b0;
                    o_res.done_res = 1'b1;
                    o_res.raw_ack  = r_ack;
                    if (r_ack == ACK_OK) begin
                        o_res.status    = r_par ? ST_PARITY : ST_OK;
                        o_res.read_data = r_data;
                    end else if (r_ack == ACK_WAIT) begin
                        o_res.status = ST_WAIT;
                    end else if (r_ack == ACK_FAULT) begin
                        o_res.status = ST_FAULT;
                    end else begin
                        o_res.status = ST_BADACK;
                    end
                    n_cnt   = '0;
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/swd_host_line_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_host_line_engine
// SWD host pin engine: read transfers and raw line sequences, one word per
// half period of SWCLK.
//
//   channel  | valid       | stall        | payload
//   ---------+-------------+--------------+-----------------------------
//   input    | i_in_valid  | o_in_stall   | i_in  (start or tick word)
//   output   | o_out_valid | i_out_stall  | o_out (line levels, result)
//
// Each accepted word yields one result word in the cycle after, held in the
// output register; a word can be taken every cycle while the output is not stalled.
// A stalled output register holds the input side off until it drains.
// Synchronous active-low reset: line idle (clock high), no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_host_line_engine #(
    parameter int SEQ_MAX_BITS = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire swdh_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output swdh_pkg::t_out      o_out
);
    import swdh_pkg::*;

    logic r_out_valid;
    t_out r_out;
    t_out core_res;
    logic step;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign step        = i_in_valid & !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    swdh_core #(
        .SEQ_MAX_BITS(SEQ_MAX_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_item (i_in),
        .o_res  (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_res;
        end
    end

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SWD host line engine.
// Drives start and tick words with random gaps and a randomly stalling
// receiver. A scoreboard class tracks the wire state, computes the line
// levels and result due for each accepted word, and checks every result word
// field by field, oldest first. Covers read transfers with every ack outcome,
// data parity errors, raw sequences of all lengths, and restarts mid-operation.
// ----------------------------------------------------------------------------

module tb;
    import swdh_pkg::*;

    localparam int         SEQ_MAX     = 64;
    localparam logic [1:0] FUNC_NONE   = 2'd3;
    localparam logic [2:0] ACK_NONE    = 3'b000;
    localparam logic [2:0] ACK_ALL     = 3'b111;
    localparam int         ACK_FIRST   = REQ_BITS + 1;
    localparam int         DATA_FIRST  = ACK_FIRST + ACK_BITS;
    localparam int         PAR_BIT     = DATA_FIRST + DATA_WIDTH;
    localparam int         NO_CUT      = 1 << 20;
    localparam int         ITEMS       = 1400;
    localparam int         HOLD_CYCLES = 300;

    class swd_line_scoreboard;
        t_phase          ph;
        int              cnt;
        bit              clk_lvl;
        logic [63:0]     shreg;
        logic [2:0]      ackr;
        logic [31:0]     dsh;
        bit              par;
        t_out            levels_due[$];
        int              mismatches;
        int              n_checked;
        int              n_seq;
        int              n_restart;
        int              n_status[8];

        function new();
            ph = PH_IDLE;
            cnt = 0;
            clk_lvl = 1'b1;
            shreg = '0;
            ackr = '0;
            dsh = '0;
            par = 1'b0;
        endfunction

        function int waiting();
            return levels_due.size();
        endfunction

        function t_out next_levels(t_in w);
            t_out r;
            int   len;
            r = '0;
            r.swclk = 1'b1;
            r.swdio_out = 1'b1;
            r.swdio_oe = 1'b1;
            if (w.func == FUNC_XFER || w.func == FUNC_SEQ) begin
                if (ph != PH_IDLE) n_restart++;
                clk_lvl = 1'b1;
                ackr = '0;
                dsh = '0;
                par = 1'b0;
                if (w.func == FUNC_XFER) begin
                    shreg = {56'd0, 1'b1, 1'b0, ^w.request, w.request, 1'b1};
                    cnt = 0;
                    ph = PH_REQ;
                end else begin
                    len = int'(w.seq_length);
                    shreg = w.seq_bits;
                    cnt = (len > SEQ_MAX) ? SEQ_MAX : len;
                    ph = PH_SEQ;
                end
                r.busy_res = 1'b1;
                return r;
            end
            if (w.func == FUNC_NONE || ph == PH_IDLE) begin
                r.swclk = clk_lvl;
                r.swdio_oe = !(ph inside {PH_TURN1, PH_ACK, PH_DATA, PH_TURN2});
                r.swdio_out = ((ph == PH_REQ || ph == PH_SEQ) && !clk_lvl) ? shreg[0] : 1'b1;
                r.busy_res = (ph != PH_IDLE);
                return r;
            end
            r.busy_res = 1'b1;
            if (ph == PH_SEQ && cnt == 0) begin
                ph = PH_IDLE;
                clk_lvl = 1'b1;
                r.busy_res = 1'b0;
                r.done_res = 1'b1;
                return r;
            end
            r.swdio_oe = (ph == PH_REQ || ph == PH_SEQ);
            if (ph == PH_REQ || ph == PH_SEQ) r.swdio_out = shreg[0];
            if (clk_lvl) begin
                // low half: drive or sample
                clk_lvl = 1'b0;
                r.swclk = 1'b0;
                if (ph == PH_ACK && cnt < ACK_BITS) ackr[cnt] = ackr[cnt] | w.swdio_in;
                if (ph == PH_DATA) begin
                    if (cnt < DATA_WIDTH) dsh = {w.swdio_in, dsh[DATA_WIDTH-1:1]};
                    par ^= w.swdio_in;
                end
                return r;
            end
            // high half: advance
            clk_lvl = 1'b1;
            case (ph)
                PH_REQ: begin
                    shreg >>= 1;
                    cnt++;
                    if (cnt >= REQ_BITS) begin
                        cnt = 0;
                        ph = PH_TURN1;
                    end
                end
                PH_SEQ: begin
                    shreg >>= 1;
                    cnt--;
                    if (cnt == 0) begin
                        r.busy_res = 1'b0;
                        r.done_res = 1'b1;
                        ph = PH_IDLE;
                    end
                end
                PH_TURN1: begin
                    cnt = 0;
                    ph = PH_ACK;
                end
                PH_ACK: begin
                    cnt++;
                    if (cnt >= ACK_BITS) begin
                        cnt = 0;
                        ph = (ackr == ACK_OK) ? PH_DATA : PH_TURN2;
                    end
                end
                PH_DATA: begin
                    cnt++;
                    if (cnt >= DATA_WIDTH + 1) begin
                        cnt = 0;
                        ph = PH_TURN2;
                    end
                end
                default: begin
                    r.busy_res = 1'b0;
                    r.done_res = 1'b1;
                    r.raw_ack = ackr;
                    if (ackr == ACK_OK) begin
                        r.status = par ? ST_PARITY : ST_OK;
                        r.read_data = dsh;
                    end else if (ackr == ACK_WAIT) begin
                        r.status = ST_WAIT;
                    end else if (ackr == ACK_FAULT) begin
                        r.status = ST_FAULT;
                    end else begin
                        r.status = ST_BADACK;
                    end
                    cnt = 0;
                    ph = PH_IDLE;
                end
            endcase
            return r;
        endfunction

        function void note(t_in w);
            t_out e;
            e = next_levels(w);
            if (e.done_res) begin
                if (e.swdio_oe) n_seq++;
                else n_status[e.status]++;
            end
            levels_due.push_back(e);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 25) $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("word %0d %s got 0x%0h want 0x%0h",
                                 n_checked, name, got, want));
        endtask

        task check(t_out got);
            t_out want;
            if (levels_due.size() == 0) begin
                report("result word with nothing outstanding");
                return;
            end
            want = levels_due.pop_front();
            n_checked++;
            field("swclk", 32'(got.swclk), 32'(want.swclk));
            field("swdio_out", 32'(got.swdio_out), 32'(want.swdio_out));
            field("swdio_oe", 32'(got.swdio_oe), 32'(want.swdio_oe));
            field("busy", 32'(got.busy_res), 32'(want.busy_res));
            field("done", 32'(got.done_res), 32'(want.done_res));
            field("status", 32'(got.status), 32'(want.status));
            field("raw_ack", 32'(got.raw_ack), 32'(want.raw_ack));
            field("read_data", got.read_data, want.read_data);
        endtask
    endclass

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_word   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_word;

    swd_line_scoreboard sb;
    bit gappy   = 1'b0;
    bit holding = 1'b0;
    bit hold_go = 1'b0;
    int n_sent  = 0;

    swd_host_line_engine #(
        .SEQ_MAX_BITS(SEQ_MAX)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_word)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.note(in_word);
            if (out_valid && !out_stall) sb.check(out_word);
        end
    end

    // receiver: free stretches, short and long stalls, one long hold on request
    initial begin
        int mode;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_go) begin
                hold_go = 1'b0;
                holding = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding = 1'b0;
            end else begin
                mode = $urandom_range(0, 9);
                if (mode < 5) begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                end else if (mode < 9) begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end else begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                end
            end
        end
    end

    function automatic t_in rand_word(logic [1:0] f);
        t_in w;
        w.func = f;
        w.request = 4'($urandom);
        w.seq_bits = {$urandom, $urandom};
        w.seq_length = 7'($urandom);
        w.swdio_in = 1'($urandom);
        return w;
    endfunction

    task automatic send_word(input t_in w);
        int k;
        int gap;
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_sent++;
        if (gappy && !holding) begin
            k = $urandom_range(0, 99);
            if (k >= 95) gap = $urandom_range(10, 40);
            else if (k >= 75) gap = $urandom_range(1, 3);
            else gap = 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic tick(input logic sdi);
        t_in w;
        w = rand_word(FUNC_TICK);
        w.swdio_in = sdi;
        send_word(w);
    endtask

    // read transfer with a target answering ack, then data and parity on an OK ack; cut ends it early
    task automatic run_xfer(input logic [3:0] req, input logic [2:0] ack,
                            input logic [31:0] data, input bit bad_par, input int cut);
        t_in  w;
        int   nbits;
        int   b;
        int   k;
        logic sdi;
        w = rand_word(FUNC_XFER);
        w.request = req;
        send_word(w);
        nbits = (ack == ACK_OK) ? PAR_BIT + 2 : DATA_FIRST + 1;
        for (k = 0; k < 2 * nbits && k < cut; k++) begin
            b = k / 2;
            sdi = 1'($urandom);
            if (k % 2 == 0) begin
                if (b >= ACK_FIRST && b < DATA_FIRST) sdi = ack[b - ACK_FIRST];
                else if (ack == ACK_OK && b >= DATA_FIRST && b < PAR_BIT)
                    sdi = data[b - DATA_FIRST];
                else if (ack == ACK_OK && b == PAR_BIT) sdi = ^data ^ bad_par;
            end
            tick(sdi);
        end
    endtask

    task automatic run_seq(input logic [63:0] bits, input logic [6:0] len, input int cut);
        t_in w;
        int  n;
        int  k;
        w = rand_word(FUNC_SEQ);
        w.seq_bits = bits;
        w.seq_length = len;
        send_word(w);
        n = (len == 0) ? 1 : 2 * ((len > SEQ_MAX) ? SEQ_MAX : int'(len));
        for (k = 0; k < n && k < cut; k++) tick(1'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.waiting() != 0) @(posedge clk);
    endtask

    initial begin
        int         pick;
        int         a;
        int         cut;
        int         len;
        bit         paused;
        logic [2:0] ack;
        sb = new();
        paused = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle ticks, unused code, zero and oversize lengths, restarts
        tick(1'b1);
        send_word(rand_word(FUNC_NONE));
        run_seq('1, 7'd0, NO_CUT);
        run_seq('1, 7'd1, NO_CUT);
        run_seq('0, 7'd127, 1);
        send_word(rand_word(FUNC_NONE));
        tick(1'b0);
        run_xfer(4'hF, ACK_OK, '1, 1'b0, 3);
        send_word(rand_word(FUNC_NONE));
        run_seq(64'hA5A5_5A5A_F00F_0FF0, 7'd64, 2);
        run_xfer(4'h0, ACK_OK, '0, 1'b0, 2);

        gappy = 1'b1;
        hold_go = 1'b1;
        run_xfer(4'($urandom), ACK_OK, '1, 1'b1, NO_CUT);
        run_xfer(4'($urandom), ACK_OK, '0, 1'b0, NO_CUT);
        run_xfer(4'($urandom), ACK_WAIT, $urandom, 1'b0, NO_CUT);
        run_xfer(4'($urandom), ACK_FAULT, $urandom, 1'b0, NO_CUT);
        run_xfer(4'($urandom), ACK_NONE, $urandom, 1'b0, NO_CUT);
        run_xfer(4'($urandom), ACK_ALL, $urandom, 1'b0, NO_CUT);

        while (n_sent < ITEMS) begin
            if (!paused && n_sent >= ITEMS / 2) begin
                paused = 1'b1;
                drain();
                hold_go = 1'b1;
            end
            gappy = ($urandom_range(0, 3) != 0);
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : NO_CUT;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                a = $urandom_range(0, 9);
                ack = (a < 6) ? ACK_OK : (a == 6) ? ACK_WAIT :
                      (a == 7) ? ACK_FAULT : 3'($urandom);
                run_xfer(4'($urandom), ack, $urandom, $urandom_range(0, 4) == 0, cut);
            end else if (pick < 88) begin
                a = $urandom_range(0, 19);
                len = (a < 14) ? $urandom_range(1, 12) :
                      (a < 17) ? $urandom_range(13, 64) :
                      (a < 18) ? 0 : $urandom_range(65, 127);
                run_seq({$urandom, $urandom}, 7'(len), cut);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_word(rand_word($urandom_range(0, 1) ? FUNC_TICK : FUNC_NONE));
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("run: %0d words checked, %0d restarts, %0d sequences done",
                 sb.n_checked, sb.n_restart, sb.n_seq);
        $display("transfers: ok %0d, wait %0d, fault %0d, bad ack %0d, parity error %0d",
                 sb.n_status[ST_OK], sb.n_status[ST_WAIT], sb.n_status[ST_FAULT],
                 sb.n_status[ST_BADACK], sb.n_status[ST_PARITY]);
        if (sb.mismatches == 0 && sb.waiting() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
